>>> hw/rtl/salts_pkg.sv
`default_nettype none

package salts_pkg;

	// widths of the item fields at the ports
	localparam int ADDR_W     = 32;
	localparam int LINE_TAG_W = 20;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;    // take a request and read its set row
		logic commit;  // resolve the request, write back, fill the result register
	} cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/set_assoc_lru_tag_store_core.sv
`default_nettype none

// Tag store of a set-associative cache with true LRU replacement. Each request
// beat carries a byte address and a mode (0 = lookup, 1 = insert); the address
// splits into block offset, set index and tag. Every request gives exactly one
// result beat: hit, and on a hit the low 20 bits of the tag. A hit makes the line
// most recent; an insert that misses fills the lowest free way of the set, or
// evicts the least recently used line when the set is full. A request first
// reads the set's tag and rank row through the registered read port of the set
// memories, then compares, updates recency and writes the row back; a stalled
// result beat holds that second step until the result register frees. Valid
// bits live in flops and are cleared at reset, so the block is ready right
// after reset with no clearing pass.
module set_assoc_lru_tag_store_core #(
	parameter int ADDRESS_WIDTH     = 32,
	parameter int INDEX_BITS        = 6,
	parameter int BLOCK_OFFSET_BITS = 6,
	parameter int WAYS              = 4
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// request channel
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire                               mode,
	input  wire  [salts_pkg::ADDR_W-1:0]      address,
	// result channel
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic                              hit,
	output logic [salts_pkg::LINE_TAG_W-1:0]  line_tag
);

	salts_pkg::cmd_t cmd;

	// sequencer: idle -> lookup -> idle, gated by the result register
	salts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// set memories, hit and victim search, recency update, result register
	salts_dp #(
		.ADDRESS_WIDTH     (ADDRESS_WIDTH),
		.INDEX_BITS        (INDEX_BITS),
		.BLOCK_OFFSET_BITS (BLOCK_OFFSET_BITS),
		.WAYS              (WAYS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.mode     (mode),
		.address  (address),
		.hit      (hit),
		.line_tag (line_tag)
	);

endmodule

`default_nettype wire

>>> hw/rtl/salts_ctrl.sv
`default_nettype none

module salts_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	output salts_pkg::cmd_t   cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// result register is free when empty or being drained this cycle
	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_valid && (state_q == ST_IDLE);
	assign cmd.commit = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/salts_dp.sv
`default_nettype none

module salts_dp #(
	parameter int ADDRESS_WIDTH     = 32,
	parameter int INDEX_BITS        = 6,
	parameter int BLOCK_OFFSET_BITS = 6,
	parameter int WAYS              = 4
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  salts_pkg::cmd_t                    cmd,
	input  wire                                mode,
	input  wire  [salts_pkg::ADDR_W-1:0]       address,
	output logic                               hit,
	output logic [salts_pkg::LINE_TAG_W-1:0]   line_tag
);

	localparam int NUM_SETS  = 1 << INDEX_BITS;
	localparam int EFF_AW    = (ADDRESS_WIDTH < salts_pkg::ADDR_W) ? ADDRESS_WIDTH
	                                                               : salts_pkg::ADDR_W;
	localparam int TAG_SPAN  = EFF_AW - INDEX_BITS - BLOCK_OFFSET_BITS;
	localparam int TW        = (TAG_SPAN > 0) ? TAG_SPAN : 1;
	localparam int RW        = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [salts_pkg::ADDR_W-1:0] AMASK =
		(ADDRESS_WIDTH >= salts_pkg::ADDR_W) ? {salts_pkg::ADDR_W{1'b1}}
		: ((salts_pkg::ADDR_W'(1) << ADDRESS_WIDTH) - salts_pkg::ADDR_W'(1));
	localparam logic [RW-1:0] OLDEST = RW'(WAYS - 1);

	// request split
	logic [salts_pkg::ADDR_W-1:0] eff_addr;
	logic [salts_pkg::ADDR_W-1:0] tag_shift;
	logic [INDEX_BITS-1:0]        set_in;
	logic [TW-1:0]                tag_in;

	assign eff_addr  = address & AMASK;
	assign tag_shift = eff_addr >> (INDEX_BITS + BLOCK_OFFSET_BITS);
	assign set_in    = eff_addr[BLOCK_OFFSET_BITS +: INDEX_BITS];
	assign tag_in    = tag_shift[TW-1:0];

	// set rows: tags and ranks in memory, valid bits in flops
	logic [WAYS*TW-1:0] tag_mem  [NUM_SETS];
	logic [WAYS*RW-1:0] rank_mem [NUM_SETS];
	logic [WAYS-1:0]    valid_q  [NUM_SETS];

	logic                  mode_s1;
	logic [INDEX_BITS-1:0] set_s1;
	logic [TW-1:0]         tag_s1;
	logic [WAYS*TW-1:0]    tag_row_s1;
	logic [WAYS*RW-1:0]    rank_row_s1;
	logic [WAYS-1:0]       vrow_s1;

	logic                  hit_q;
	logic [salts_pkg::LINE_TAG_W-1:0] line_tag_q;

	// resolve
	logic [WAYS-1:0]    vrow;
	logic [WAYS-1:0]    match;
	logic [WAYS-1:0]    is_oldest;
	logic               found;
	logic [WAY_W-1:0]   hit_way;
	logic [WAY_W-1:0]   free_way;
	logic [WAY_W-1:0]   old_way;
	logic [WAY_W-1:0]   sel_way;
	logic               full;
	logic               alloc;
	logic               do_write;
	logic [RW-1:0]      hit_rank;
	logic [WAYS*TW-1:0] new_tag_row;
	logic [WAYS*RW-1:0] new_rank_row;
	logic [WAYS-1:0]    new_vrow;
	logic [salts_pkg::ADDR_W-1:0] tag_ext;

	assign vrow = vrow_s1;
	assign full = &vrow;

	always_comb begin
		match     = '0;
		is_oldest = '0;
		for (int i = 0; i < WAYS; i++) begin
			match[i]     = vrow[i] && (tag_row_s1[i*TW +: TW] == tag_s1);
			is_oldest[i] = (rank_row_s1[i*RW +: RW] == OLDEST);
		end
	end

	// lowest-numbered way wins in each encoder
	always_comb begin
		hit_way  = '0;
		free_way = '0;
		old_way  = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_way = WAY_W'(i);
			end
			if (!vrow[i]) begin
				free_way = WAY_W'(i);
			end
			if (is_oldest[i]) begin
				old_way = WAY_W'(i);
			end
		end
	end

	assign found    = |match;
	assign alloc    = !found && mode_s1;
	assign do_write = found || mode_s1;
	assign sel_way  = found ? hit_way : (full ? old_way : free_way);
	assign hit_rank = rank_row_s1[hit_way*RW +: RW];

	always_comb begin
		new_tag_row  = tag_row_s1;
		new_rank_row = rank_row_s1;
		new_vrow     = vrow;
		for (int i = 0; i < WAYS; i++) begin
			if (WAY_W'(i) == sel_way) begin
				new_rank_row[i*RW +: RW] = '0;
				if (alloc) begin
					new_tag_row[i*TW +: TW] = tag_s1;
					new_vrow[i]             = 1'b1;
				end
			end else if (vrow[i] && (alloc || (rank_row_s1[i*RW +: RW] < hit_rank))) begin
				new_rank_row[i*RW +: RW] = rank_row_s1[i*RW +: RW] + RW'(1);
			end
		end
	end

	assign tag_ext = salts_pkg::ADDR_W'(tag_s1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_s1     <= mode;
			set_s1      <= set_in;
			tag_s1      <= tag_in;
			tag_row_s1  <= tag_mem[set_in];
			rank_row_s1 <= rank_mem[set_in];
			vrow_s1     <= valid_q[set_in];
		end
		if (cmd.commit && do_write) begin
			tag_mem[set_s1]  <= new_tag_row;
			rank_mem[set_s1] <= new_rank_row;
		end
		if (cmd.commit) begin
			hit_q      <= found;
			line_tag_q <= found ? tag_ext[salts_pkg::LINE_TAG_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else if (cmd.commit && alloc) begin
			valid_q[set_s1] <= new_vrow;
		end
	end

	assign hit      = hit_q;
	assign line_tag = line_tag_q;

endmodule

`default_nettype wire
